>>> design/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Types, codes and the per-byte lexing step for the source code tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_NUMDOT,
    MODE_WORD,
    MODE_STR,
    MODE_PLUS,
    MODE_MINUS,
    MODE_DISCARD
  } mode_t;

  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  localparam logic [4:0] K_NUMBER     = 5'd0;
  localparam logic [4:0] K_WORD       = 5'd1;
  localparam logic [4:0] K_STRING     = 5'd2;
  localparam logic [4:0] K_PLUSPLUS   = 5'd3;
  localparam logic [4:0] K_PLUS       = 5'd4;
  localparam logic [4:0] K_MINUSMINUS = 5'd5;
  localparam logic [4:0] K_MINUS      = 5'd6;
  localparam logic [4:0] K_STAR       = 5'd7;
  localparam logic [4:0] K_SLASH      = 5'd8;
  localparam logic [4:0] K_PERCENT    = 5'd9;
  localparam logic [4:0] K_ASSIGN     = 5'd10;
  localparam logic [4:0] K_LPAREN     = 5'd11;
  localparam logic [4:0] K_RPAREN     = 5'd12;
  localparam logic [4:0] K_LBRACE     = 5'd13;
  localparam logic [4:0] K_RBRACE     = 5'd14;
  localparam logic [4:0] K_COMMA      = 5'd15;
  localparam logic [4:0] K_SEMI       = 5'd16;
  localparam logic [4:0] K_EOP        = 5'd17;
  localparam logic [4:0] K_NONE       = 5'd0;

  localparam logic ERR_DOT    = 1'b0;
  localparam logic ERR_STRING = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  typedef struct packed {
    logic [1:0] event_res;
    logic [4:0] token_kind;
    logic [7:0] char_value;
    logic       error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic  emit;
    res_t  res;
    mode_t mode;
  } idle_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
    mode_t      mode;
  } step_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic [4:0] single_op(logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2a:   k = K_STAR;
      8'h2f:   k = K_SLASH;
      8'h25:   k = K_PERCENT;
      8'h3d:   k = K_ASSIGN;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h2c:   k = K_COMMA;
      8'h3b:   k = K_SEMI;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(logic [1:0] ev, logic [4:0] kind, logic [7:0] ch,
                                  logic err);
    res_t r;
    r.event_res  = ev;
    r.token_kind = kind;
    r.char_value = ch;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  // byte seen with no token open
  function automatic idle_t from_idle(logic [7:0] c);
    idle_t      d;
    logic [4:0] k;
    k      = single_op(c);
    d.emit = 1'b0;
    d.res  = '0;
    d.mode = MODE_IDLE;
    if (c == CH_NUL) begin
      d.emit = 1'b1;
      d.res  = mk_res(EV_END, K_EOP, CH_NUL, 1'b0);
    end else if (c == CH_QUOTE) begin
      d.mode = MODE_STR;
    end else if (is_dig(c)) begin
      d.emit = 1'b1;
      d.res  = mk_res(EV_CHAR, K_NONE, c, 1'b0);
      d.mode = MODE_NUM;
    end else if (c == CH_PLUS) begin
      d.mode = MODE_PLUS;
    end else if (c == CH_MINUS) begin
      d.mode = MODE_MINUS;
    end else if (k != K_NONE) begin
      d.emit = 1'b1;
      d.res  = mk_res(EV_END, k, CH_NUL, 1'b0);
    end else if (is_alpha(c)) begin
      d.emit = 1'b1;
      d.res  = mk_res(EV_CHAR, K_NONE, c, 1'b0);
      d.mode = MODE_WORD;
    end
    return d;
  endfunction

  function automatic step_t lex_step(mode_t mode, logic [7:0] c);
    step_t s;
    idle_t d;
    d       = from_idle(c);
    s.count = 2'd0;
    s.r0    = '0;
    s.r1    = '0;
    s.mode  = mode;
    case (mode)
      MODE_NUM: begin
        if (is_dig(c)) begin
          s.count = 2'd1;
          s.r0    = mk_res(EV_CHAR, K_NONE, c, 1'b0);
        end else if (c == CH_DOT) begin
          s.count = 2'd1;
          s.r0    = mk_res(EV_CHAR, K_NONE, c, 1'b0);
          s.mode  = MODE_NUMDOT;
        end else begin
          s.r0    = mk_res(EV_END, K_NUMBER, CH_NUL, 1'b0);
          s.r1    = d.res;
          s.count = d.emit ? 2'd2 : 2'd1;
          s.mode  = d.mode;
        end
      end
      MODE_NUMDOT: begin
        s.count = 2'd1;
        if (is_dig(c)) begin
          s.r0   = mk_res(EV_CHAR, K_NONE, c, 1'b0);
          s.mode = MODE_NUM;
        end else begin
          s.r0   = mk_res(EV_ERR, K_NONE, CH_NUL, ERR_DOT);
          s.mode = (c == CH_NUL) ? MODE_IDLE : MODE_DISCARD;
        end
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_dig(c)) begin
          s.count = 2'd1;
          s.r0    = mk_res(EV_CHAR, K_NONE, c, 1'b0);
        end else begin
          s.r0    = mk_res(EV_END, K_WORD, CH_NUL, 1'b0);
          s.r1    = d.res;
          s.count = d.emit ? 2'd2 : 2'd1;
          s.mode  = d.mode;
        end
      end
      MODE_STR: begin
        s.count = 2'd1;
        if (c == CH_QUOTE) begin
          s.r0   = mk_res(EV_END, K_STRING, CH_NUL, 1'b0);
          s.mode = MODE_IDLE;
        end else if (c == CH_NUL) begin
          s.r0   = mk_res(EV_ERR, K_NONE, CH_NUL, ERR_STRING);
          s.mode = MODE_IDLE;
        end else begin
          s.r0 = mk_res(EV_CHAR, K_NONE, c, 1'b0);
        end
      end
      MODE_PLUS: begin
        if (c == CH_PLUS) begin
          s.count = 2'd1;
          s.r0    = mk_res(EV_END, K_PLUSPLUS, CH_NUL, 1'b0);
          s.mode  = MODE_IDLE;
        end else begin
          s.r0    = mk_res(EV_END, K_PLUS, CH_NUL, 1'b0);
          s.r1    = d.res;
          s.count = d.emit ? 2'd2 : 2'd1;
          s.mode  = d.mode;
        end
      end
      MODE_MINUS: begin
        if (c == CH_MINUS) begin
          s.count = 2'd1;
          s.r0    = mk_res(EV_END, K_MINUSMINUS, CH_NUL, 1'b0);
          s.mode  = MODE_IDLE;
        end else begin
          s.r0    = mk_res(EV_END, K_MINUS, CH_NUL, 1'b0);
          s.r1    = d.res;
          s.count = d.emit ? 2'd2 : 2'd1;
          s.mode  = d.mode;
        end
      end
      MODE_DISCARD: begin
        if (c == CH_NUL) begin
          s.mode = MODE_IDLE;
        end
      end
      default: begin
        s.r0    = d.res;
        s.count = d.emit ? 2'd1 : 2'd0;
        s.mode  = d.mode;
      end
    endcase
    if (s.count == 2'd1) begin
      s.r0.last = 1'b1;
    end
    if (s.count == 2'd2) begin
      s.r1.last = 1'b1;
    end
    return s;
  endfunction

endpackage

>>> design/source_code_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_code_tokenizer_unit
// Streaming lexer for a small C-like language, one source byte per transfer.
// ----------------------------------------------------------------------------
// Input channel text_valid/text_stall/text_byte carries one source byte per
// transfer; a zero byte ends a text. Output channel res_valid/res_stall carries
// result items: token characters, token ends with their kind, and errors.
// A byte may cause zero, one or two results; last marks the final one.
// Each byte taken is held in the input register, lexed combinationally, and
// written into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while res_stall stays low. The two-entry
// result queue drains one result per cycle while res_stall is low, so a byte
// that causes two results can hold off input until both fit in the queue.
// When res_stall is high the queue fills, and once it has no room for the
// next byte's results text_stall rises; no result is dropped.
// Reset clears the lexing mode to idle and empties the input register and
// the result queue.
// ----------------------------------------------------------------------------
module source_code_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] event_res,
  output logic [4:0] token_kind,
  output logic [7:0] char_value,
  output logic       error_code,
  output logic       last
);

  logic                 in_v;
  logic [7:0]           in_byte;
  sct_pkg::mode_t       mode;
  sct_pkg::mode_t       mode_next;
  sct_pkg::step_t       step;
  sct_pkg::res_t        q [2];
  sct_pkg::res_t        q_next [2];
  logic [1:0]           cnt;
  logic [1:0]           cnt_next;
  logic [1:0]           free;
  logic [1:0]           base;
  logic                 pop;
  logic                 fire;

  always_comb begin
    step = sct_pkg::lex_step(mode, in_byte);
  end

  assign pop        = (cnt != 2'd0) && !res_stall;
  assign free       = 2'd2 - cnt + {1'b0, pop};
  assign fire       = in_v && (step.count <= free);
  assign text_stall = in_v && !fire;
  assign base       = cnt - {1'b0, pop};

  always_comb begin
    mode_next = fire ? step.mode : mode;
  end

  always_comb begin
    cnt_next  = base + (fire ? step.count : 2'd0);
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = q[1];
    if (fire) begin
      case (step.count)
        2'd1: begin
          q_next[base[0]] = step.r0;
        end
        2'd2: begin
          q_next[0] = step.r0;
          q_next[1] = step.r1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      cnt  <= 2'd0;
      mode <= sct_pkg::MODE_IDLE;
    end else begin
      if (!text_stall) begin
        in_v <= text_valid;
      end
      cnt  <= cnt_next;
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_byte <= text_byte;
    end
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  assign res_valid  = (cnt != 2'd0);
  assign event_res  = q[0].event_res;
  assign token_kind = q[0].token_kind;
  assign char_value = q[0].char_value;
  assign error_code = q[0].error_code;
  assign last       = q[0].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2)
    else $error("result queue overfilled");

  a_pair_fills: assert property (@(posedge clk) disable iff (rst)
    fire && (step.count == 2'd2) |=> cnt == 2'd2)
    else $error("two-result byte did not fill the queue");

  a_discard_quiet: assert property (@(posedge clk) disable iff (rst)
    in_v && (mode == sct_pkg::MODE_DISCARD) |-> step.count == 2'd0)
    else $error("result produced while discarding");

  a_err_no_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == sct_pkg::EV_ERR) |-> token_kind == sct_pkg::K_NONE)
    else $error("error result carries a kind");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    text_stall |=> $stable(in_byte) && in_v)
    else $error("held byte lost while stalling");

endmodule
